// ----- rtl/cabq_pkg.sv -----
// Package for the channel-state amplitude and bar quantizer.
// Holds the sequencer state type, fixed field widths and the bar level function.
// No dependencies.
package cabq_pkg;

	localparam int AMP_W       = 7;
	localparam int IDX_W       = 6;
	localparam int BAR_IDX_W   = 5;
	localparam int LEVEL_W     = 3;
	localparam int SAMPLE_W    = 8;
	localparam int MAG_W       = 16;
	localparam int ROOT_STEPS  = 8;
	localparam int STEP_W      = 3;

	localparam logic [AMP_W-1:0]   AMP_MAX   = 7'd127;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 3'd4;
	localparam logic [MAG_W-1:0]   ROOT_BIT_INIT = 16'h4000;

	// smallest avg that reaches each level: ceil(k * AMP_MAX / LEVEL_MAX)
	localparam logic [AMP_W-1:0] LEVEL1_MIN =
		AMP_W'((1 * int'(AMP_MAX) + int'(LEVEL_MAX) - 1) / int'(LEVEL_MAX));
	localparam logic [AMP_W-1:0] LEVEL2_MIN =
		AMP_W'((2 * int'(AMP_MAX) + int'(LEVEL_MAX) - 1) / int'(LEVEL_MAX));
	localparam logic [AMP_W-1:0] LEVEL3_MIN =
		AMP_W'((3 * int'(AMP_MAX) + int'(LEVEL_MAX) - 1) / int'(LEVEL_MAX));
	localparam logic [AMP_W-1:0] LEVEL4_MIN =
		AMP_W'((4 * int'(AMP_MAX) + int'(LEVEL_MAX) - 1) / int'(LEVEL_MAX));

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ_RE,
		ST_SQ_IM,
		ST_ROOT,
		ST_DONE
	} state_t;

	// floor(avg * LEVEL_MAX / AMP_MAX) as threshold compares, clamped at LEVEL_MAX
	function automatic logic [LEVEL_W-1:0] bar_level_f(input logic [AMP_W-1:0] avg);
		logic [LEVEL_W-1:0] lvl;
		lvl = '0;
		if (avg >= LEVEL1_MIN) lvl = LEVEL_W'(1);
		if (avg >= LEVEL2_MIN) lvl = LEVEL_W'(2);
		if (avg >= LEVEL3_MIN) lvl = LEVEL_W'(3);
		if (avg >= LEVEL4_MIN) lvl = LEVEL_MAX;
		return lvl;
	endfunction

endpackage

// ----- rtl/csi_amplitude_bar_quantizer.sv -----
// Top level of the channel-state amplitude and bar quantizer.
// Depends on cabq_pkg for the state type, widths and bar level function.
//
// Takes one subcarrier sample per item and returns its magnitude
// floor(sqrt(re^2 + im^2)) saturated at 127, its position in the frame and,
// on the second sample of each of the first BAR_COUNT pairs, a bar level 0..4.
// A captured sample passes through these steps from acceptance until its result
// sits in the output register: one 8x8 multiplier squares the two parts in turn,
// then one shared add/compare/subtract unit runs the 8-step digit-by-digit
// root, and the done state forms the bar level and loads the result. in_ready is
// low for that whole span and while a finished result waits for a full
// output register. A dropped sample (capture disabled, or past CARRIERS)
// is taken while the sequencer is idle and gives no result.
module csi_amplitude_bar_quantizer
	import cabq_pkg::*;
#(
	parameter int CARRIERS  = 52,
	parameter int BAR_COUNT = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  capture_enable_we,
	input  logic                  capture_enable,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [SAMPLE_W-1:0] imag_part,
	input  logic signed [SAMPLE_W-1:0] real_part,
	input  logic                  frame_end,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [AMP_W-1:0]      amplitude,
	output logic [IDX_W-1:0]      carrier_index,
	output logic                  bar_valid,
	output logic [BAR_IDX_W-1:0]  bar_index,
	output logic [LEVEL_W-1:0]    bar_level,
	output logic                  frame_last
);

	localparam int POS_W = $clog2(CARRIERS + 1);

	state_t state_q, state_d;

	logic                     capture_q;
	logic [POS_W-1:0]         pos_q;
	logic [AMP_W-1:0]         pair_q;

	logic signed [SAMPLE_W-1:0] im_q, re_q;
	logic                     fend_q;
	logic [POS_W-1:0]         item_pos_q;
	logic [MAG_W-1:0]         v_q, root_q, bit_q;
	logic [STEP_W-1:0]        step_q;

	logic                     take, start, deliver;
	logic                     pos_in_frame;
	logic signed [SAMPLE_W-1:0] sq_op;
	logic signed [MAG_W-1:0]  sq;
	logic [MAG_W:0]           trial;
	logic                     fits;
	logic [AMP_W-1:0]         amp;
	logic                     in_pairs;
	logic [AMP_W:0]           pair_sum;
	logic [AMP_W-1:0]         avg;

	logic                     out_valid_q;
	logic [AMP_W-1:0]         amplitude_q;
	logic [IDX_W-1:0]         carrier_index_q;
	logic                     bar_valid_q;
	logic [BAR_IDX_W-1:0]     bar_index_q;
	logic [LEVEL_W-1:0]       bar_level_q;
	logic                     frame_last_q;

	assign pos_in_frame = 32'(pos_q) < 32'(CARRIERS);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && capture_q && pos_in_frame) state_d = ST_SQ_RE;
			end
			ST_SQ_RE: state_d = ST_SQ_IM;
			ST_SQ_IM: state_d = ST_ROOT;
			ST_ROOT: begin
				if (step_q == STEP_W'(ROOT_STEPS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == ST_IDLE);
		take     = in_valid && in_ready;
		start    = take && capture_q && pos_in_frame;
		deliver  = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	end

	assign sq_op = (state_q == ST_SQ_RE) ? re_q : im_q;
	assign sq    = MAG_W'(sq_op * sq_op);
	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign fits  = {1'b0, v_q} >= trial;

	assign amp      = (root_q >= MAG_W'(AMP_MAX)) ? AMP_MAX : root_q[AMP_W-1:0];
	assign in_pairs = 32'(item_pos_q) < 32'(2 * BAR_COUNT);
	assign pair_sum = {1'b0, pair_q} + {1'b0, amp};
	assign avg      = pair_sum[AMP_W:1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			capture_q <= 1'b1;
			pos_q     <= '0;
			pair_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (capture_enable_we) capture_q <= capture_enable;
			if (take && capture_q) begin
				if (!pos_in_frame) begin
					if (frame_end) pos_q <= '0;
				end else begin
					pos_q <= frame_end ? '0 : pos_q + POS_W'(1);
				end
			end
			if (deliver && in_pairs && !item_pos_q[0]) pair_q <= amp;
			if (deliver) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			im_q       <= imag_part;
			re_q       <= real_part;
			fend_q     <= frame_end;
			item_pos_q <= pos_q;
		end
		case (state_q)
			ST_SQ_RE: v_q <= sq;
			ST_SQ_IM: begin
				v_q    <= v_q + sq;
				root_q <= '0;
				bit_q  <= ROOT_BIT_INIT;
				step_q <= '0;
			end
			ST_ROOT: begin
				if (fits) begin
					v_q    <= v_q - trial[MAG_W-1:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
		if (deliver) begin
			amplitude_q     <= amp;
			carrier_index_q <= IDX_W'(item_pos_q);
			frame_last_q    <= fend_q;
			if (in_pairs && item_pos_q[0]) begin
				bar_valid_q <= 1'b1;
				bar_index_q <= BAR_IDX_W'(item_pos_q >> 1);
				bar_level_q <= bar_level_f(avg);
			end else begin
				bar_valid_q <= 1'b0;
				bar_index_q <= '0;
				bar_level_q <= '0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign amplitude     = amplitude_q;
	assign carrier_index = carrier_index_q;
	assign bar_valid     = bar_valid_q;
	assign bar_index     = bar_index_q;
	assign bar_level     = bar_level_q;
	assign frame_last    = frame_last_q;

endmodule
